FILE: rtl/core/idec_pkg.sv
// ----------------------------------------------------------------------------
// idec_pkg
// Shared constants and codes for the input debounce / event detector.
// ----------------------------------------------------------------------------
package idec_pkg;

    // default width of the tick counter since the last raw change
    localparam int DURATION_BITS_DEF = 16;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int DUR_OUT_W   = 16;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET = 16'd100;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLUMP         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EVENT_ENABLE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HOLD   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INACTIVE_HOLD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HIGH   = 3'd5;

    // event_enable bit positions
    localparam int EN_RAW_ACT   = 0;
    localparam int EN_RAW_INACT = 1;
    localparam int EN_DEB_ACT   = 2;
    localparam int EN_DEB_INACT = 3;

    // event codes (raw, debounced and hold events)
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_ACTIVE   = 2'd1;
    localparam logic [1:0] EV_INACTIVE = 2'd2;

    // button state codes
    localparam logic [1:0] BTN_NONE      = 2'd0;
    localparam logic [1:0] BTN_PUSHED    = 2'd1;
    localparam logic [1:0] BTN_HELD_LONG = 2'd2;

    // result beat layout in m_tdata
    localparam int OUT_DATA_W      = 32;
    localparam int OUT_RAW_STATE   = 0;
    localparam int OUT_DEB_STATE   = 1;
    localparam int OUT_RAW_EV_LO   = 2;
    localparam int OUT_DEB_EV_LO   = 4;
    localparam int OUT_HOLD_EV_LO  = 6;
    localparam int OUT_BUTTON_LO   = 8;
    localparam int OUT_DUR_LO      = 10;

endpackage

FILE: rtl/core/input_debounce_event_detector.sv
// ----------------------------------------------------------------------------
// input_debounce_event_detector
// Per-tick pin debouncer with raw/debounced/hold events and button state.
// ----------------------------------------------------------------------------
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------
//  s_       | in        | one tick: pin level in s_tdata[0]
//  m_       | out       | one result per tick: states, events, duration
//  cfg_     | in        | register write: cfg_index selects, cfg_data value
//
//  Throughput: one tick per cycle unless m_tready stalls. Input register,
//  then result register; state update and all compares sit between them.
//  Reset: aresetn synchronous, active low; clears state and valids, loads config reset values.
//  Stalls: while a result waits on m_tready the input register still takes
//  one more beat; s_tready drops only when both registers are full.
//  cfg_ready is always high; write only while the block is idle.
// ----------------------------------------------------------------------------
module input_debounce_event_detector #(
    parameter int DURATION_BITS = idec_pkg::DURATION_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: [0] pin_level, [7:1] zero
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,
    // m_tdata: [0] raw_state, [1] debounced_state, [3:2] raw_event,
    // [5:4] debounced_event, [7:6] hold_event, [9:8] button_state,
    // [25:10] since_change, [31:26] zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [idec_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [idec_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [idec_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // compare width covers both the counter and the 16-bit registers
    localparam int CMP_W = (DURATION_BITS > idec_pkg::CFG_DATA_W) ?
                           DURATION_BITS : idec_pkg::CFG_DATA_W;
    localparam logic [DURATION_BITS-1:0] TICKS_MAX = {DURATION_BITS{1'b1}};
    localparam logic [CMP_W-1:0] DUR_SAT =
        CMP_W'({idec_pkg::DUR_OUT_W{1'b1}});

    // configuration
    logic [15:0] debounce_reg;
    logic [15:0] clump_reg;
    logic [3:0]  event_enable_reg;
    logic [15:0] active_hold_reg;
    logic [15:0] inactive_hold_reg;
    logic        active_high_reg;

    // detector state
    logic                     raw_level_reg,       raw_level_next;
    logic                     deb_level_reg,       deb_level_next;
    logic [DURATION_BITS-1:0] level_ticks_reg,     level_ticks_next;
    logic                     hold_reported_reg,   hold_reported_next;
    logic                     press_pending_reg,   press_pending_next;

    // pipeline
    logic                           in_valid_reg;
    logic                           in_pin_reg;
    logic                           out_valid_reg;
    logic [idec_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                           advance;

    // combinational per-tick results
    logic             level;
    logic [1:0]       raw_ev, deb_ev, hold_ev, button;
    logic [CMP_W-1:0] ticks_ext;
    logic [15:0]      duration;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb begin
        level              = in_pin_reg ^ ~active_high_reg;
        raw_level_next     = raw_level_reg;
        deb_level_next     = deb_level_reg;
        level_ticks_next   = level_ticks_reg;
        hold_reported_next = hold_reported_reg;
        press_pending_next = press_pending_reg;
        raw_ev             = idec_pkg::EV_NONE;
        deb_ev             = idec_pkg::EV_NONE;
        hold_ev            = idec_pkg::EV_NONE;
        button             = idec_pkg::BTN_NONE;
        ticks_ext          = '0;

        if (level != raw_level_reg) begin
            // change tick: restart the duration, skip debounce and hold checks
            level_ticks_next   = '0;
            hold_reported_next = 1'b0;
            raw_level_next     = level;
            if (level && event_enable_reg[idec_pkg::EN_RAW_ACT]) begin
                raw_ev = idec_pkg::EV_ACTIVE;
            end else if (!level && event_enable_reg[idec_pkg::EN_RAW_INACT]) begin
                raw_ev = idec_pkg::EV_INACTIVE;
            end
        end else begin
            if (level_ticks_reg != TICKS_MAX) begin
                level_ticks_next = level_ticks_reg + 1'b1;
            end
            ticks_ext = CMP_W'(level_ticks_next);
            if (ticks_ext >= CMP_W'(debounce_reg) && deb_level_reg != raw_level_reg) begin
                deb_level_next     = raw_level_reg;
                press_pending_next = 1'b1;
                if (raw_level_reg && event_enable_reg[idec_pkg::EN_DEB_ACT]) begin
                    deb_ev = idec_pkg::EV_ACTIVE;
                end else if (!raw_level_reg && event_enable_reg[idec_pkg::EN_DEB_INACT]) begin
                    deb_ev = idec_pkg::EV_INACTIVE;
                end
            end
            // one-shot per level period
            if (!hold_reported_reg) begin
                if (raw_level_reg && active_hold_reg != '0 &&
                    ticks_ext >= CMP_W'(active_hold_reg)) begin
                    hold_ev            = idec_pkg::EV_ACTIVE;
                    hold_reported_next = 1'b1;
                end else if (!raw_level_reg && inactive_hold_reg != '0 &&
                             ticks_ext >= CMP_W'(inactive_hold_reg)) begin
                    hold_ev            = idec_pkg::EV_INACTIVE;
                    hold_reported_next = 1'b1;
                end
            end
        end

        ticks_ext = CMP_W'(level_ticks_next);

        // pushed wins over held long
        if (press_pending_next && deb_level_next) begin
            button             = idec_pkg::BTN_PUSHED;
            press_pending_next = 1'b0;
        end else if (raw_level_next && ticks_ext >= CMP_W'(clump_reg)) begin
            button = idec_pkg::BTN_HELD_LONG;
        end

        if (ticks_ext > DUR_SAT) begin
            duration = 16'hFFFF;
        end else begin
            duration = ticks_ext[15:0];
        end

        out_data_next = '0;
        out_data_next[idec_pkg::OUT_RAW_STATE]       = raw_level_next;
        out_data_next[idec_pkg::OUT_DEB_STATE]       = deb_level_next;
        out_data_next[idec_pkg::OUT_RAW_EV_LO  +: 2] = raw_ev;
        out_data_next[idec_pkg::OUT_DEB_EV_LO  +: 2] = deb_ev;
        out_data_next[idec_pkg::OUT_HOLD_EV_LO +: 2] = hold_ev;
        out_data_next[idec_pkg::OUT_BUTTON_LO  +: 2] = button;
        out_data_next[idec_pkg::OUT_DUR_LO     +: idec_pkg::DUR_OUT_W] = duration;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg      <= idec_pkg::DEBOUNCE_RESET;
            clump_reg         <= '0;
            event_enable_reg  <= '0;
            active_hold_reg   <= '0;
            inactive_hold_reg <= '0;
            active_high_reg   <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                idec_pkg::REG_DEBOUNCE: begin
                    // zero debounce is refused
                    if (cfg_data != '0) begin
                        debounce_reg <= cfg_data;
                    end
                end
                idec_pkg::REG_CLUMP:         clump_reg         <= cfg_data;
                idec_pkg::REG_EVENT_ENABLE:  event_enable_reg  <= cfg_data[3:0];
                idec_pkg::REG_ACTIVE_HOLD:   active_hold_reg   <= cfg_data;
                idec_pkg::REG_INACTIVE_HOLD: inactive_hold_reg <= cfg_data;
                idec_pkg::REG_ACTIVE_HIGH:   active_high_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register, detector state, result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            raw_level_reg     <= 1'b0;
            deb_level_reg     <= 1'b0;
            level_ticks_reg   <= '0;
            hold_reported_reg <= 1'b0;
            press_pending_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_pin_reg   <= s_tdata[0];
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg     <= 1'b1;
                out_data_reg      <= out_data_next;
                raw_level_reg     <= raw_level_next;
                deb_level_reg     <= deb_level_next;
                level_ticks_reg   <= level_ticks_next;
                hold_reported_reg <= hold_reported_next;
                press_pending_reg <= press_pending_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/idec_checker.sv
// ----------------------------------------------------------------------------
// idec_checker
// Port-level assertions for the debounce / event detector, bound to the top.
// ----------------------------------------------------------------------------
module idec_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [idec_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic        raw_st, deb_st;
    logic [1:0]  raw_ev, deb_ev, hold_ev, button;
    logic [15:0] dur;

    assign raw_st  = m_tdata[idec_pkg::OUT_RAW_STATE];
    assign deb_st  = m_tdata[idec_pkg::OUT_DEB_STATE];
    assign raw_ev  = m_tdata[idec_pkg::OUT_RAW_EV_LO  +: 2];
    assign deb_ev  = m_tdata[idec_pkg::OUT_DEB_EV_LO  +: 2];
    assign hold_ev = m_tdata[idec_pkg::OUT_HOLD_EV_LO +: 2];
    assign button  = m_tdata[idec_pkg::OUT_BUTTON_LO  +: 2];
    assign dur     = m_tdata[idec_pkg::OUT_DUR_LO     +: idec_pkg::DUR_OUT_W];

    // stalled result beat holds
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // a raw change restarts the duration; hold events never fire on it
    a_raw_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && raw_ev != idec_pkg::EV_NONE |->
            dur == '0 && hold_ev == idec_pkg::EV_NONE)
        else $error("raw event without duration restart");

    // an active raw or hold event comes with the raw state active
    a_raw_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (raw_ev == idec_pkg::EV_ACTIVE || hold_ev == idec_pkg::EV_ACTIVE)
            |-> raw_st)
        else $error("active event with inactive raw state");

    // debounced event leaves debounced state equal to raw state
    a_deb_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && deb_ev != idec_pkg::EV_NONE |->
            deb_st == raw_st && (deb_ev == idec_pkg::EV_ACTIVE) == deb_st)
        else $error("debounced event inconsistent with states");

    // pushed only while debounced active
    a_pushed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && button == idec_pkg::BTN_PUSHED |-> deb_st)
        else $error("pushed reported with debounced level inactive");

endmodule

bind input_debounce_event_detector idec_checker u_idec_checker (.*);

FILE: sim/tb_input_debounce_event_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_input_debounce_event_detector
// Self-checking bench for the per-tick debouncer. A short directed table
// covers reset values, masking, ignored writes and the change-tick rules.
// Randomized phases follow, each with fresh register settings: mostly bounce
// bursts followed by steady runs, plus noise. The last phase uses top-end
// register settings. Every result beat is compared field by field against a
// typed-in report or a bench-side shadow of the debouncer.
// ----------------------------------------------------------------------------
module tb_input_debounce_event_detector;

    localparam int  LATENCY_PAD     = 6;        // settle pad past the pipe latency
    localparam int  HOLD_OFF_CYCLES = 48;       // long sink stall, fills the pipe
    localparam int  RANDOM_PHASES   = 12;
    localparam int  PHASE_TICKS     = 130;      // minimum ticks per random phase
    localparam int  FINAL_RUN_TICKS = 40;
    localparam longint CYCLE_LIMIT  = 1000000;

    // register slots past the list; writes there must be dropped
    localparam logic [idec_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [idec_pkg::CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam logic [15:0] PIN_LOW  = 16'd0;
    localparam logic [15:0] PIN_HIGH = 16'd1;

    // one result beat, same order as m_tdata from the top bit down
    typedef struct packed {
        logic [idec_pkg::DUR_OUT_W-1:0] duration;
        logic [1:0]           button;
        logic [1:0]           hold_ev;
        logic [1:0]           deb_ev;
        logic [1:0]           raw_ev;
        logic                 deb_state;
        logic                 raw_state;
    } tick_report_t;

    localparam tick_report_t NO_REPORT = '0;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    // tick rows carry the pin in value[0]; cfg rows carry index and data
    typedef struct packed {
        row_kind_t                          kind;
        logic [idec_pkg::CFG_INDEX_W-1:0]   index;
        logic [idec_pkg::CFG_DATA_W-1:0]    value;
        logic                               has_report;   // report below is typed in
        tick_report_t                       report;
    } stim_row_t;

    // report fields: duration, button, hold, debounced ev, raw ev, deb, raw
    localparam stim_row_t DIRECTED [0:28] = '{
        // reset settings: debounce 100, nothing enabled, pin high is active
        '{ROW_TICK, '0, PIN_LOW, 1'b1,
          '{16'd1, idec_pkg::BTN_NONE, idec_pkg::EV_NONE, idec_pkg::EV_NONE,
            idec_pkg::EV_NONE, 1'b0, 1'b0}},
        // clump 0 at reset: held long on the very change tick
        '{ROW_TICK, '0, PIN_HIGH, 1'b1,
          '{16'd0, idec_pkg::BTN_HELD_LONG, idec_pkg::EV_NONE, idec_pkg::EV_NONE,
            idec_pkg::EV_NONE, 1'b0, 1'b1}},
        '{ROW_TICK, '0, PIN_LOW, 1'b1,
          '{16'd0, idec_pkg::BTN_NONE, idec_pkg::EV_NONE, idec_pkg::EV_NONE,
            idec_pkg::EV_NONE, 1'b0, 1'b0}},
        '{ROW_CFG, idec_pkg::REG_DEBOUNCE, 16'h0000, 1'b0, NO_REPORT},       // dropped
        '{ROW_CFG, idec_pkg::REG_EVENT_ENABLE, 16'hFFFF, 1'b0, NO_REPORT},   // masks to 4'hF
        '{ROW_CFG, idec_pkg::REG_CLUMP, 16'd4, 1'b0, NO_REPORT},
        '{ROW_CFG, idec_pkg::REG_ACTIVE_HOLD, 16'd3, 1'b0, NO_REPORT},
        '{ROW_CFG, idec_pkg::REG_INACTIVE_HOLD, 16'd2, 1'b0, NO_REPORT},
        '{ROW_CFG, REG_UNUSED_LO, 16'hFFFF, 1'b0, NO_REPORT},
        '{ROW_CFG, REG_UNUSED_HI, 16'h0000, 1'b0, NO_REPORT},
        '{ROW_CFG, idec_pkg::REG_DEBOUNCE, 16'd2, 1'b0, NO_REPORT},
        // inactive hold, then press: debounce, pushed, active hold, held long
        '{ROW_TICK, '0, PIN_LOW, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_LOW, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_HIGH, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_HIGH, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_HIGH, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_HIGH, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_HIGH, 1'b0, NO_REPORT},
        // release with a bounce, then debounce to inactive
        '{ROW_TICK, '0, PIN_LOW, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_HIGH, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_LOW, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_LOW, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_LOW, 1'b0, NO_REPORT},
        // polarity flip via a masked write, clump 0 again
        '{ROW_CFG, idec_pkg::REG_ACTIVE_HIGH, 16'hFFFE, 1'b0, NO_REPORT},
        '{ROW_CFG, idec_pkg::REG_CLUMP, 16'd0, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_HIGH, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_LOW, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_LOW, 1'b0, NO_REPORT},
        '{ROW_TICK, '0, PIN_HIGH, 1'b0, NO_REPORT}
    };

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [idec_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [idec_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [idec_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // shadow of the debouncer: registers
    logic [15:0] sh_deb_time    = idec_pkg::DEBOUNCE_RESET;
    logic [15:0] sh_clump_time  = '0;
    logic [3:0]  sh_ev_mask     = '0;
    logic [15:0] sh_act_hold    = '0;
    logic [15:0] sh_inact_hold  = '0;
    logic        sh_act_high    = 1'b1;
    // shadow of the debouncer: level tracking
    logic        sh_raw         = 1'b0;
    logic        sh_debounced   = 1'b0;
    logic [idec_pkg::DURATION_BITS_DEF-1:0] sh_ticks = '0;
    logic        sh_hold_fired  = 1'b0;
    logic        sh_press_armed = 1'b0;

    tick_report_t reports_due [$];
    int     err_count    = 0;
    longint cycle_count  = 0;
    bit     stream_busy  = 1'b0;   // ticks sent since the last settle
    bit     steady_flow  = 1'b0;   // no idling on either side
    bit     hold_off_req = 1'b0;   // ask the sink for one long stall

    input_debounce_event_detector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Step the shadow by one tick and return the beat it should produce.
    function automatic tick_report_t advance_debouncer(input logic pin);
        tick_report_t r;
        logic         lvl;
        r   = '0;
        lvl = pin ^ ~sh_act_high;
        if (lvl != sh_raw) begin
            // change tick: restart count, no debounce or hold checks
            sh_ticks      = '0;
            sh_hold_fired = 1'b0;
            if (lvl && sh_ev_mask[idec_pkg::EN_RAW_ACT])
                r.raw_ev = idec_pkg::EV_ACTIVE;
            else if (!lvl && sh_ev_mask[idec_pkg::EN_RAW_INACT])
                r.raw_ev = idec_pkg::EV_INACTIVE;
            sh_raw = lvl;
        end else begin
            if (sh_ticks != '1)
                sh_ticks++;
            if (sh_ticks >= sh_deb_time && sh_debounced != sh_raw) begin
                sh_debounced   = sh_raw;
                sh_press_armed = 1'b1;
                if (sh_raw && sh_ev_mask[idec_pkg::EN_DEB_ACT])
                    r.deb_ev = idec_pkg::EV_ACTIVE;
                else if (!sh_raw && sh_ev_mask[idec_pkg::EN_DEB_INACT])
                    r.deb_ev = idec_pkg::EV_INACTIVE;
            end
            // hold events ignore the enable mask, one per level period
            if (!sh_hold_fired) begin
                if (sh_raw && sh_act_hold != '0 && sh_ticks >= sh_act_hold) begin
                    r.hold_ev     = idec_pkg::EV_ACTIVE;
                    sh_hold_fired = 1'b1;
                end else if (!sh_raw && sh_inact_hold != '0 &&
                             sh_ticks >= sh_inact_hold) begin
                    r.hold_ev     = idec_pkg::EV_INACTIVE;
                    sh_hold_fired = 1'b1;
                end
            end
        end
        // a pending press wins over held long
        if (sh_press_armed && sh_debounced) begin
            r.button       = idec_pkg::BTN_PUSHED;
            sh_press_armed = 1'b0;
        end else if (sh_raw && sh_ticks >= sh_clump_time) begin
            r.button = idec_pkg::BTN_HELD_LONG;
        end
        r.raw_state = sh_raw;
        r.deb_state = sh_debounced;
        r.duration  = sh_ticks;
        return r;
    endfunction

    function automatic logic [15:0] pick_time();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 16));
        endcase
    endfunction

    // Drop valid and wait until every expected beat is back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge aclk);
        repeat (LATENCY_PAD) @(posedge aclk);
        stream_busy = 1'b0;
    endtask

    // cfg_valid stays up for back-to-back writes; the next tick lowers it.
    task automatic write_reg(input logic [idec_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [idec_pkg::CFG_DATA_W-1:0]  val);
        if (stream_busy)
            settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            idec_pkg::REG_DEBOUNCE:      if (val != '0) sh_deb_time = val;
            idec_pkg::REG_CLUMP:         sh_clump_time = val;
            idec_pkg::REG_EVENT_ENABLE:  sh_ev_mask    = val[3:0];
            idec_pkg::REG_ACTIVE_HOLD:   sh_act_hold   = val;
            idec_pkg::REG_INACTIVE_HOLD: sh_inact_hold = val;
            idec_pkg::REG_ACTIVE_HIGH:   sh_act_high   = val[0];
            default: ;
        endcase
    endtask

    task automatic send_tick(input logic pin, input logic has_report = 1'b0,
                             input tick_report_t report = '0);
        tick_report_t predicted;
        cfg_valid <= 1'b0;
        if (!steady_flow && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, pin};
        do @(posedge aclk); while (!s_tready);
        predicted = advance_debouncer(pin);
        reports_due.push_back(has_report ? report : predicted);
        stream_busy = 1'b1;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            err_count++;
        end
    endtask

    // result sink: random stalls, a quiet stretch, one long hold-off
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES - 1;
                m_tready    <= 1'b0;
            end else begin
                m_tready <= steady_flow || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        tick_report_t want;
        tick_report_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.raw_state = m_tdata[idec_pkg::OUT_RAW_STATE];
            got.deb_state = m_tdata[idec_pkg::OUT_DEB_STATE];
            got.raw_ev    = m_tdata[idec_pkg::OUT_RAW_EV_LO +: 2];
            got.deb_ev    = m_tdata[idec_pkg::OUT_DEB_EV_LO +: 2];
            got.hold_ev   = m_tdata[idec_pkg::OUT_HOLD_EV_LO +: 2];
            got.button    = m_tdata[idec_pkg::OUT_BUTTON_LO +: 2];
            got.duration  = m_tdata[idec_pkg::OUT_DUR_LO +: idec_pkg::DUR_OUT_W];
            if (reports_due.size() == 0) begin
                $display("%0t ns: unexpected result beat, expected none, actual %h",
                         $time, got);
                err_count++;
            end else begin
                want = reports_due.pop_front();
                check_field("raw_state",       32'(want.raw_state), 32'(got.raw_state));
                check_field("debounced_state", 32'(want.deb_state), 32'(got.deb_state));
                check_field("raw_event",       32'(want.raw_ev),    32'(got.raw_ev));
                check_field("debounced_event", 32'(want.deb_ev),    32'(got.deb_ev));
                check_field("hold_event",      32'(want.hold_ev),   32'(got.hold_ev));
                check_field("button_state",    32'(want.button),    32'(got.button));
                check_field("since_change",    32'(want.duration),  32'(got.duration));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int   phase_ticks;
        int   bounces;
        int   run_len;
        logic target;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < $size(DIRECTED); i++) begin
            if (DIRECTED[i].kind == ROW_CFG)
                write_reg(DIRECTED[i].index, DIRECTED[i].value);
            else
                send_tick(DIRECTED[i].value[0], DIRECTED[i].has_report,
                          DIRECTED[i].report);
        end

        // random phases, each with its own register settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_reg(idec_pkg::REG_DEBOUNCE, pick_time());
            write_reg(idec_pkg::REG_CLUMP, pick_time());
            write_reg(idec_pkg::REG_EVENT_ENABLE, 16'($urandom_range(0, 65535)));
            write_reg(idec_pkg::REG_ACTIVE_HOLD, pick_time());
            write_reg(idec_pkg::REG_INACTIVE_HOLD, pick_time());
            write_reg(idec_pkg::REG_ACTIVE_HIGH, 16'($urandom_range(0, 65535)));
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                          16'($urandom_range(0, 65535)));
            steady_flow = (ph == 6);
            if (ph == 3)
                hold_off_req = 1'b1;
            phase_ticks = 0;
            while (phase_ticks < PHASE_TICKS) begin
                if ($urandom_range(0, 9) < 8) begin
                    // contact bounce, then a steady level
                    target  = 1'($urandom_range(0, 1));
                    bounces = $urandom_range(0, 4);
                    run_len = $urandom_range(1, 40);
                    for (int b = 0; b < bounces; b++)
                        send_tick((b % 2) ? target : ~target);
                    repeat (run_len) send_tick(target);
                    phase_ticks += bounces + run_len;
                end else begin
                    run_len = $urandom_range(1, 8);
                    repeat (run_len) send_tick(1'($urandom_range(0, 1)));
                    phase_ticks += run_len;
                end
            end
        end

        // top-end settings, a steady level, then three ticks at the other level
        steady_flow = 1'b1;
        write_reg(idec_pkg::REG_DEBOUNCE, 16'hFFFF);
        write_reg(idec_pkg::REG_CLUMP, 16'hFFFF);
        write_reg(idec_pkg::REG_EVENT_ENABLE, 16'h000F);
        write_reg(idec_pkg::REG_ACTIVE_HOLD, 16'hFFFF);
        write_reg(idec_pkg::REG_INACTIVE_HOLD, 16'hFFFF);
        write_reg(idec_pkg::REG_ACTIVE_HIGH, 16'($urandom_range(0, 1)));
        target = 1'($urandom_range(0, 1));
        repeat (FINAL_RUN_TICKS) send_tick(target);
        repeat (3) send_tick(~target);
        steady_flow = 1'b0;

        settle();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
